@@ src/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen on a clk_i edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ src/rtpjm_pkg.sv @@
// Package for the RTP stream lock and jitter monitor: types, widths and constants.
`default_nettype none

package rtpjm_pkg;

  // Default RTP clock rate in ticks per millisecond
  localparam int unsigned TICKS_PER_MS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_IP        = 3'd0,
    REG_MIN_LENGTH      = 3'd1,
    REG_MASTER_MODE     = 3'd2,
    REG_PRESET_LOCK     = 3'd3,
    REG_PRESET_OUT_SSRC = 3'd4,
    REG_PRESET_IN_SSRC  = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] MIN_LENGTH_RST = 16'd34;

  // Accepted RTP versions
  localparam logic [1:0] RTP_VER1 = 2'd1;
  localparam logic [1:0] RTP_VER2 = 2'd2;

  // Stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 264;

  // Jitter datapath
  localparam int unsigned US_PER_MS  = 1000;
  localparam int unsigned RA_W       = 10;   // remainder modulo 1000
  localparam int unsigned QA_W       = 22;   // 32-bit value divided by 1000
  localparam int unsigned DIF_W      = 32;
  localparam int unsigned JIT_W      = 40;
  localparam int unsigned AVG_TERM_W = 45;   // DIF_W x 13-bit coefficient
  localparam int unsigned AVG_SUM_W  = 57;
  localparam int unsigned RFC_SUM_W  = 45;

  // Moving average 0.9 / 0.1 in Q16, rounded
  localparam int unsigned AVG_OLD = 58982;
  localparam int unsigned AVG_NEW = 6554;
  localparam int unsigned AVG_RND = 32768;

  // Estimator gain 1/16, rounded
  localparam int unsigned RFC_OLD = 15;
  localparam int unsigned RFC_RND = 8;

  // Per-packet side information carried down the pipeline
  typedef struct packed {
    logic        rec;
    logic        dir;
    logic        report;
    logic        do_jit;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [31:0] arr;
    logic [31:0] lock_out;
    logic [31:0] lock_in;
  } meta_t;

endpackage

`default_nettype wire

@@ src/rtpjm_jitter_pipe.sv @@
// Pipelined transit-time difference datapath for the jitter estimators.
`default_nettype none

module rtpjm_jitter_pipe import rtpjm_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = TICKS_PER_MS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire meta_t                 meta_i,
  input  wire logic [31:0]           da_i,       // arrival delta, two's complement
  input  wire logic [31:0]           dt_i,       // timestamp delta, two's complement
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output meta_t                      meta_o,
  output logic [AVG_TERM_W-1:0]      avg_term_o, // AVG_NEW * dif
  output logic [DIF_W-1:0]           dif1_o
);

  localparam int unsigned NSTG = 5;

  // Exact reciprocal for dt / TICKS_PER_MS over 32-bit magnitudes
  localparam int unsigned TL      = $clog2(TICKS_PER_MS);
  localparam int unsigned ST      = 32 + TL;
  localparam logic [63:0] RT_FULL = ((64'd1 << ST) + 64'(TICKS_PER_MS) - 64'd1)
                                    / 64'(TICKS_PER_MS);
  localparam logic [32:0] RT      = RT_FULL[32:0];

  // Exact reciprocal for x / 1000 over 32-bit magnitudes
  localparam int unsigned SK      = 32 + RA_W;
  localparam logic [63:0] RK_FULL = ((64'd1 << SK) + 64'(US_PER_MS) - 64'd1)
                                    / 64'(US_PER_MS);
  localparam logic [32:0] RK      = RK_FULL[32:0];

  // Remainder times ticks, then divided by 1000
  localparam int unsigned RAT_W   = $clog2(((US_PER_MS - 1) * TICKS_PER_MS) + 1);
  localparam int unsigned S3      = RAT_W + RA_W;
  localparam int unsigned R3_W    = RAT_W + 1;
  localparam logic [63:0] R3_FULL = ((64'd1 << S3) + 64'(US_PER_MS) - 64'd1)
                                    / 64'(US_PER_MS);
  localparam logic [R3_W-1:0] R3  = R3_FULL[R3_W-1:0];
  localparam int unsigned PF_W    = RAT_W + R3_W;

  localparam int unsigned QAT_W   = QA_W + $clog2(TICKS_PER_MS + 1);
  localparam int unsigned M1_W    = QAT_W + 1;
  localparam int unsigned D1_W    = ((M1_W > 32) ? M1_W : 32) + 2;
  localparam int unsigned QT1K_W  = 32 + RA_W;
  localparam int unsigned DS_W    = QT1K_W + 2;

  // Stage handshake
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;
  meta_t           meta_q [NSTG];

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_valid_i;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      meta_q[0] <= meta_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // Stage 0: magnitudes and reciprocal multiplies
  logic [31:0] am;
  logic [31:0] tm;
  logic [64:0] pt;
  logic [64:0] pa;
  logic [31:0] qt0_q;
  logic [QA_W-1:0] qa0_q;
  logic [31:0] am0_q;
  logic [31:0] da0_q;
  logic [31:0] dt0_q;

  always_comb begin
    am = da_i[31] ? (~da_i + 32'd1) : da_i;
    tm = dt_i[31] ? (~dt_i + 32'd1) : dt_i;
    pt = 65'(tm) * 65'(RT);
    pa = 65'(am) * 65'(RK);
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      qt0_q <= 32'(pt >> ST);
      qa0_q <= QA_W'(pa >> SK);
      am0_q <= am;
      da0_q <= da_i;
      dt0_q <= dt_i;
    end
  end

  // Stage 1: scale quotients back, remainder of |da| / 1000
  logic [31:0] qk1;
  logic [31:0] ra;
  logic [QT1K_W-1:0] qt1k1_q;
  logic [RA_W-1:0]   ra1_q;
  logic [QAT_W-1:0]  qat1_q;
  logic [31:0]       da1_q;
  logic [31:0]       dt1_q;

  always_comb begin
    qk1 = 32'(qa0_q) * 32'(US_PER_MS);
    ra  = am0_q - qk1;
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      qt1k1_q <= QT1K_W'(qt0_q) * QT1K_W'(US_PER_MS);
      ra1_q   <= ra[RA_W-1:0];
      qat1_q  <= QAT_W'(qa0_q) * QAT_W'(TICKS_PER_MS);
      da1_q   <= da0_q;
      dt1_q   <= dt0_q;
    end
  end

  // Stage 2: microsecond difference |da - (dt / T) * 1000|, saturated
  logic [DS_W-1:0]  dax;
  logic [DS_W-1:0]  qx;
  logic [DS_W-1:0]  dsum;
  logic [DS_W-1:0]  dmag;
  logic [DIF_W-1:0] dif;
  logic [RAT_W-1:0] rat2_q;
  logic [QAT_W-1:0] qat2_q;
  logic [DIF_W-1:0] dif2_q;
  logic             sa2_q;
  logic [31:0]      dt2_q;

  always_comb begin
    dax  = {{(DS_W-32){da1_q[31]}}, da1_q};
    qx   = DS_W'(qt1k1_q);
    // quotient is negative when dt is negative
    dsum = dt1_q[31] ? (dax + qx) : (dax - qx);
    dmag = dsum[DS_W-1] ? (~dsum + DS_W'(1)) : dsum;
    dif  = (|dmag[DS_W-1:DIF_W]) ? '1 : dmag[DIF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      rat2_q <= RAT_W'(ra1_q) * RAT_W'(TICKS_PER_MS);
      qat2_q <= qat1_q;
      dif2_q <= dif;
      sa2_q  <= da1_q[31];
      dt2_q  <= dt1_q;
    end
  end

  // Stage 3: |da| * T / 1000 = qa * T + (ra * T) / 1000
  logic [PF_W-1:0]  pf;
  logic [M1_W-1:0]  m1;
  logic [M1_W-1:0]  m13_q;
  logic [DIF_W-1:0] dif3_q;
  logic             sa3_q;
  logic [31:0]      dt3_q;

  always_comb begin
    pf = PF_W'(rat2_q) * PF_W'(R3);
    m1 = M1_W'(qat2_q) + M1_W'(pf >> S3);
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      m13_q  <= m1;
      dif3_q <= dif2_q;
      sa3_q  <= sa2_q;
      dt3_q  <= dt2_q;
    end
  end

  // Stage 4: tick difference |da * T / 1000 - dt|, saturated; weighted us term
  logic [D1_W-1:0]  mx;
  logic [D1_W-1:0]  dtx;
  logic [D1_W-1:0]  d1s;
  logic [D1_W-1:0]  d1m;
  logic [DIF_W-1:0] d1;
  logic [AVG_TERM_W-1:0] term4_q;
  logic [DIF_W-1:0]      dif14_q;

  always_comb begin
    mx  = D1_W'(m13_q);
    dtx = {{(D1_W-32){dt3_q[31]}}, dt3_q};
    d1s = sa3_q ? ((~mx + D1_W'(1)) - dtx) : (mx - dtx);
    d1m = d1s[D1_W-1] ? (~d1s + D1_W'(1)) : d1s;
    d1  = (|d1m[D1_W-1:DIF_W]) ? '1 : d1m[DIF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      term4_q <= AVG_TERM_W'(dif3_q) * AVG_TERM_W'(AVG_NEW);
      dif14_q <= d1;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign meta_o      = meta_q[NSTG-1];
  assign avg_term_o  = term4_q;
  assign dif1_o      = dif14_q;

endmodule

`default_nettype wire

@@ src/rtp_stream_lock_jitter_monitor.sv @@
// RTP stream lock and jitter monitor: classification, locks, pipeline and output stage.
// Input register, five datapath stages and output register lie ahead of m_axis_tvalid.
// Throughput: one packet per cycle unless m_axis_tready stalls the output; every
// stage has its own valid bit, so bubbles fill while a finished result waits. The
// jitter update is a 40x16 and a 40x4 multiply-add.
// Reset: locks, jitter state and all valid bits clear; min_length resets to 34.
`default_nettype none

`include "assert_macros.svh"

module rtp_stream_lock_jitter_monitor import rtpjm_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = TICKS_PER_MS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // packet_length, rtp_version, marker, src_ip, rtp_timestamp, ssrc, seq_num,
  // arrival_us (lowest bit up), zero pad to 168
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // record_valid, direction, rec_seq_num, rec_timestamp, rec_ssrc, rec_arrival,
  // jitter_us_q8, jitter_rtp_q8, report_locks, locked_out_ssrc, locked_in_ssrc
  // (lowest bit up), zero pad to 264
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Input fields
  logic [15:0] in_len;
  logic [1:0]  in_ver;
  logic        in_mark;
  logic [31:0] in_sip;
  logic [31:0] in_ts;
  logic [31:0] in_ssrc;
  logic [15:0] in_seq;
  logic [31:0] in_arr;

  assign in_len  = s_axis_tdata[15:0];
  assign in_ver  = s_axis_tdata[17:16];
  assign in_mark = s_axis_tdata[18];
  assign in_sip  = s_axis_tdata[50:19];
  assign in_ts   = s_axis_tdata[82:51];
  assign in_ssrc = s_axis_tdata[114:83];
  assign in_seq  = s_axis_tdata[130:115];
  assign in_arr  = s_axis_tdata[162:131];

  // Configuration registers
  logic [31:0] local_ip_q;
  logic [15:0] min_len_q;
  logic        master_q;
  logic [31:0] preset_out_q;
  logic [31:0] preset_in_q;
  logic        preset_set;

  assign preset_set = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_PRESET_LOCK) && cfg_data_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q   <= '0;
      min_len_q    <= MIN_LENGTH_RST;
      master_q     <= 1'b0;
      preset_out_q <= '0;
      preset_in_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LOCAL_IP:        local_ip_q   <= cfg_data_i;
        REG_MIN_LENGTH:      min_len_q    <= cfg_data_i[15:0];
        REG_MASTER_MODE:     master_q     <= cfg_data_i[0];
        REG_PRESET_OUT_SSRC: preset_out_q <= cfg_data_i;
        REG_PRESET_IN_SSRC:  preset_in_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stream state
  logic        out_locked_q;
  logic        in_locked_q;
  logic [31:0] out_lock_ssrc_q;
  logic [31:0] in_lock_ssrc_q;
  logic        last_valid_q;
  logic [31:0] last_ts_q;
  logic [31:0] last_arr_q;

  // Classification and lock decision for the packet on the slave side
  logic        s_acc;
  logic        pass;
  logic        incoming;
  logic        start;
  logic        out_start;
  logic        in_start;
  logic        out_lock_nx;
  logic        in_lock_nx;
  logic [31:0] out_ssrc_nx;
  logic [31:0] in_ssrc_nx;
  logic        rec_out;
  logic        rec_in;
  logic        rec;
  meta_t       meta_d;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pass        = (in_len >= min_len_q) && (in_ver inside {RTP_VER1, RTP_VER2});
    incoming    = in_sip != local_ip_q;
    start       = in_mark && (in_ts == 32'd0);
    out_start   = pass && !incoming && !out_locked_q && start;
    in_start    = pass && incoming && !in_locked_q && start;
    out_lock_nx = out_locked_q || out_start;
    in_lock_nx  = in_locked_q || in_start;
    out_ssrc_nx = out_start ? in_ssrc : out_lock_ssrc_q;
    in_ssrc_nx  = in_start ? in_ssrc : in_lock_ssrc_q;
    rec_out     = pass && !incoming && out_lock_nx && (out_ssrc_nx == in_ssrc);
    rec_in      = pass && incoming && in_lock_nx && (in_ssrc_nx == in_ssrc);
    rec         = rec_out || rec_in;

    meta_d.rec      = rec;
    meta_d.dir      = pass && incoming;
    meta_d.report   = master_q && ((out_start && in_locked_q) || (in_start && out_locked_q));
    meta_d.do_jit   = rec_in && last_valid_q;
    meta_d.seq      = rec ? in_seq : '0;
    meta_d.ts       = rec ? in_ts : '0;
    meta_d.ssrc     = rec ? in_ssrc : '0;
    meta_d.arr      = rec ? in_arr : '0;
    meta_d.lock_out = out_lock_nx ? out_ssrc_nx : '0;
    meta_d.lock_in  = in_lock_nx ? in_ssrc_nx : '0;
  end

  // Locks: preset write sets both, otherwise first start packet per direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_locked_q    <= 1'b0;
      in_locked_q     <= 1'b0;
      out_lock_ssrc_q <= '0;
      in_lock_ssrc_q  <= '0;
    end else if (preset_set) begin
      out_locked_q    <= 1'b1;
      in_locked_q     <= 1'b1;
      out_lock_ssrc_q <= preset_out_q;
      in_lock_ssrc_q  <= preset_in_q;
    end else if (s_acc) begin
      out_locked_q    <= out_lock_nx;
      in_locked_q     <= in_lock_nx;
      out_lock_ssrc_q <= out_ssrc_nx;
      in_lock_ssrc_q  <= in_ssrc_nx;
    end
  end

  // Previous recorded incoming packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
      last_ts_q    <= '0;
      last_arr_q   <= '0;
    end else if (s_acc && rec_in) begin
      last_valid_q <= 1'b1;
      last_ts_q    <= in_ts;
      last_arr_q   <= in_arr;
    end
  end

  // Input register stage
  logic        p1_vld_q;
  meta_t       p1_meta_q;
  logic [31:0] p1_da_q;
  logic [31:0] p1_dt_q;
  logic        pipe_in_ready;

  assign s_axis_tready = !p1_vld_q || pipe_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      p1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_meta_q <= meta_d;
      p1_da_q   <= in_arr - last_arr_q;
      p1_dt_q   <= in_ts - last_ts_q;
    end
  end

  // Difference datapath
  logic                  pipe_out_valid;
  meta_t                 pipe_meta;
  logic [AVG_TERM_W-1:0] pipe_term;
  logic [DIF_W-1:0]      pipe_dif1;
  logic                  out_rdy;

  rtpjm_jitter_pipe #(
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_jitter_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p1_vld_q),
    .in_ready_o  (pipe_in_ready),
    .meta_i      (p1_meta_q),
    .da_i        (p1_da_q),
    .dt_i        (p1_dt_q),
    .out_valid_o (pipe_out_valid),
    .out_ready_i (out_rdy),
    .meta_o      (pipe_meta),
    .avg_term_o  (pipe_term),
    .dif1_o      (pipe_dif1)
  );

  // Jitter recurrences
  logic [JIT_W-1:0]     avg_q;
  logic [JIT_W-1:0]     rfc_q;
  logic [AVG_SUM_W-1:0] avg_sum;
  logic [RFC_SUM_W-1:0] rfc_sum;
  logic [JIT_W:0]       avg_wide;
  logic [JIT_W:0]       rfc_wide;
  logic [JIT_W-1:0]     avg_d;
  logic [JIT_W-1:0]     rfc_d;

  always_comb begin
    avg_sum  = AVG_SUM_W'(avg_q) * AVG_SUM_W'(AVG_OLD)
             + AVG_SUM_W'({pipe_term, 8'b0}) + AVG_SUM_W'(AVG_RND);
    rfc_sum  = RFC_SUM_W'(rfc_q) * RFC_SUM_W'(RFC_OLD)
             + RFC_SUM_W'({pipe_dif1, 8'b0}) + RFC_SUM_W'(RFC_RND);
    avg_wide = avg_sum[AVG_SUM_W-1:16];
    rfc_wide = rfc_sum[RFC_SUM_W-1:4];
    avg_d    = avg_wide[JIT_W] ? '1 : avg_wide[JIT_W-1:0];
    rfc_d    = rfc_wide[JIT_W] ? '1 : rfc_wide[JIT_W-1:0];
  end

  // Output register; jitter state moves with the result it belongs to
  logic  out_vld_q;
  meta_t out_meta_q;
  logic  out_ld;

  assign out_rdy = !out_vld_q || m_axis_tready;
  assign out_ld  = pipe_out_valid && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      avg_q     <= '0;
      rfc_q     <= '0;
    end else begin
      if (out_rdy) begin
        out_vld_q <= pipe_out_valid;
      end
      if (out_ld && pipe_meta.do_jit) begin
        avg_q <= avg_d;
        rfc_q <= rfc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_meta_q <= pipe_meta;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_meta_q.lock_in, out_meta_q.lock_out, out_meta_q.report,
                          rfc_q, avg_q, out_meta_q.arr, out_meta_q.ssrc, out_meta_q.ts,
                          out_meta_q.seq, out_meta_q.dir, out_meta_q.rec};

  // Checks
  `ASSERT_CLK(a_out_lock_sticky, out_locked_q |=> out_locked_q, "outgoing lock lost")
  `ASSERT_CLK(a_in_lock_sticky, in_locked_q |=> in_locked_q, "incoming lock lost")
  `ASSERT_CLK(a_jit_hold, !out_ld |=> $stable(avg_q) && $stable(rfc_q), "jitter moved")
  `ASSERT_CLK(a_last_hold, !s_acc |=> $stable(last_arr_q) && $stable(last_ts_q), "last moved")
  `ASSERT_NEVER(a_report_rec, m_axis_tvalid && out_meta_q.report && !out_meta_q.rec, "report")

endmodule

`default_nettype wire

@@ verif/rtp_stream_lock_jitter_monitor_checker.sv @@
// Scoreboard for the RTP lock/jitter monitor: predicts each packet's record and compares.
module rtp_stream_lock_jitter_monitor_checker import rtpjm_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = TICKS_PER_MS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TICKS = TICKS_PER_MS;

  // One parsed packet, first field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] arrival_us;
    logic [15:0] seq_num;
    logic [31:0] ssrc;
    logic [31:0] rtp_ts;
    logic [31:0] src_ip;
    logic        marker;
    logic [1:0]  rtp_ver;
    logic [15:0] pkt_len;
  } rtp_packet_t;

  // One record on the master side, first field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] locked_in_ssrc;
    logic [31:0] locked_out_ssrc;
    logic        report_locks;
    logic [39:0] jitter_rtp_q8;
    logic [39:0] jitter_us_q8;
    logic [31:0] rec_arrival;
    logic [31:0] rec_ssrc;
    logic [31:0] rec_timestamp;
    logic [15:0] rec_seq_num;
    logic        direction;
    logic        record_valid;
  } rtp_record_t;

  // Register copies
  logic [31:0] host_ip;
  logic [15:0] len_floor;
  logic        master_en;
  logic [31:0] preset_tx_ssrc, preset_rx_ssrc;

  // Lock and jitter state
  logic        tx_locked, rx_locked;
  logic [31:0] tx_ssrc, rx_ssrc;
  logic        prev_valid;
  logic [31:0] prev_ts, prev_arrival;
  logic [39:0] jit_avg_q8, jit_rfc_q8;

  rtp_record_t pending_records[$];
  int          fail_total = 0;

  function automatic logic [63:0] abs_clip32(input longint v);
    if (v < 0) v = -v;
    return (v > 64'sh0000_0000_FFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF : v;
  endfunction

  // Moving average and interarrival estimator update for a recorded incoming packet
  function automatic void fold_jitter(input logic [31:0] ts, input logic [31:0] arr);
    logic signed [31:0] da32, dt32;
    longint             da, dt;
    logic [63:0]        dif_us, dif_tk, avg_next, rfc_next;
    if (prev_valid) begin
      da32 = arr - prev_arrival;
      dt32 = ts - prev_ts;
      da = longint'(da32);
      dt = longint'(dt32);
      dif_us = abs_clip32(da - (dt / TICKS) * 1000);
      dif_tk = abs_clip32((da * TICKS) / 1000 - dt);
      avg_next = (64'd58982 * jit_avg_q8 + 64'd6554 * (dif_us << 8) + 64'd32768) >> 16;
      rfc_next = (64'd15 * jit_rfc_q8 + (dif_tk << 8) + 64'd8) >> 4;
      jit_avg_q8 = (avg_next > 64'hFF_FFFF_FFFF) ? '1 : avg_next[39:0];
      jit_rfc_q8 = (rfc_next > 64'hFF_FFFF_FFFF) ? '1 : rfc_next[39:0];
    end
    prev_ts = ts;
    prev_arrival = arr;
    prev_valid = 1'b1;
  endfunction

  // Classify one packet, update the locks and jitter, build its record
  function automatic rtp_record_t monitor_packet(input rtp_packet_t p);
    rtp_record_t r;
    logic        start;
    r = '0;
    if (p.pkt_len >= len_floor && (p.rtp_ver == RTP_VER1 || p.rtp_ver == RTP_VER2)) begin
      start = p.marker && (p.rtp_ts == 32'd0);
      r.direction = (p.src_ip != host_ip);
      if (!r.direction) begin
        if (!tx_locked && start) begin
          tx_locked = 1'b1;
          tx_ssrc = p.ssrc;
          r.report_locks = master_en && rx_locked;
        end
        r.record_valid = tx_locked && (tx_ssrc == p.ssrc);
      end else begin
        if (!rx_locked && start) begin
          rx_locked = 1'b1;
          rx_ssrc = p.ssrc;
          r.report_locks = master_en && tx_locked;
        end
        r.record_valid = rx_locked && (rx_ssrc == p.ssrc);
        if (r.record_valid) fold_jitter(p.rtp_ts, p.arrival_us);
      end
      if (r.record_valid) begin
        r.rec_seq_num = p.seq_num;
        r.rec_timestamp = p.rtp_ts;
        r.rec_ssrc = p.ssrc;
        r.rec_arrival = p.arrival_us;
      end
    end
    r.jitter_us_q8 = jit_avg_q8;
    r.jitter_rtp_q8 = jit_rfc_q8;
    r.locked_out_ssrc = tx_locked ? tx_ssrc : 32'd0;
    r.locked_in_ssrc = rx_locked ? rx_ssrc : 32'd0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_total++;
    end
  endfunction

  function automatic void compare_record(input rtp_record_t got, input rtp_record_t want);
    check_field("record_valid", 64'(got.record_valid), 64'(want.record_valid));
    check_field("direction", 64'(got.direction), 64'(want.direction));
    check_field("rec_seq_num", 64'(got.rec_seq_num), 64'(want.rec_seq_num));
    check_field("rec_timestamp", 64'(got.rec_timestamp), 64'(want.rec_timestamp));
    check_field("rec_ssrc", 64'(got.rec_ssrc), 64'(want.rec_ssrc));
    check_field("rec_arrival", 64'(got.rec_arrival), 64'(want.rec_arrival));
    check_field("jitter_us_q8", 64'(got.jitter_us_q8), 64'(want.jitter_us_q8));
    check_field("jitter_rtp_q8", 64'(got.jitter_rtp_q8), 64'(want.jitter_rtp_q8));
    check_field("report_locks", 64'(got.report_locks), 64'(want.report_locks));
    check_field("locked_out_ssrc", 64'(got.locked_out_ssrc), 64'(want.locked_out_ssrc));
    check_field("locked_in_ssrc", 64'(got.locked_in_ssrc), 64'(want.locked_in_ssrc));
  endfunction

  // Watch config writes and both stream channels
  always @(posedge clk_i or negedge rst_ni) begin
    rtp_record_t got;
    if (!rst_ni) begin
      host_ip = '0;
      len_floor = MIN_LENGTH_RST;
      master_en = 1'b0;
      preset_tx_ssrc = '0;
      preset_rx_ssrc = '0;
      tx_locked = 1'b0;
      rx_locked = 1'b0;
      tx_ssrc = '0;
      rx_ssrc = '0;
      prev_valid = 1'b0;
      prev_ts = '0;
      prev_arrival = '0;
      jit_avg_q8 = '0;
      jit_rfc_q8 = '0;
      pending_records.delete();
    end else begin
      // result transaction: match against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_records.size() == 0) begin
          $display("%0t: unexpected record, expected none got %0h", $time, got);
          fail_total++;
        end else begin
          compare_record(got, pending_records.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOCAL_IP:        host_ip = cfg_data_i;
          REG_MIN_LENGTH:      len_floor = cfg_data_i[15:0];
          REG_MASTER_MODE:     master_en = cfg_data_i[0];
          REG_PRESET_LOCK: begin
            if (cfg_data_i[0]) begin
              tx_locked = 1'b1;
              rx_locked = 1'b1;
              tx_ssrc = preset_tx_ssrc;
              rx_ssrc = preset_rx_ssrc;
            end
          end
          REG_PRESET_OUT_SSRC: preset_tx_ssrc = cfg_data_i;
          REG_PRESET_IN_SSRC:  preset_rx_ssrc = cfg_data_i;
          default: ;
        endcase
      end
      // input transaction: predict its record
      if (s_axis_tvalid && s_axis_tready)
        pending_records.push_back(monitor_packet(s_axis_tdata));
    end
    pending_o <= pending_records.size();
    fail_count_o <= fail_total;
  end

endmodule

@@ verif/rtp_stream_lock_jitter_monitor_test.sv @@
// Top of the RTP lock/jitter monitor testbench: clock, reset, stimulus and verdict.
module rtp_stream_lock_jitter_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpjm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  localparam logic [31:0] HOST_A = 32'hC0A8_0001;
  localparam logic [31:0] PEER_A = 32'h0A00_0001;
  localparam logic [31:0] TX_SSRC_A = 32'h1234_5678;
  localparam logic [31:0] RX_SSRC_A = 32'h8765_4321;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int fail_count, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // What the stimulus knows about the current setup and streams
  logic [31:0] host_ip_now = '0;
  logic [15:0] len_floor_now = MIN_LENGTH_RST;
  logic [31:0] tx_ssrc_now, rx_ssrc_now;
  logic [31:0] preset_tx_val, preset_rx_val;
  logic [31:0] rx_ts = '0, rx_arrival = '0;
  logic [15:0] seq_ctr = '0;

  rtp_stream_lock_jitter_monitor #(.TICKS_PER_MS(TICKS_PER_MS_DEF)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  rtp_stream_lock_jitter_monitor_checker #(.TICKS_PER_MS(TICKS_PER_MS_DEF)) monitor_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rtp_stream_lock_jitter_monitor_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one packet, with random sender gaps, and wait for its transaction
  task automatic push_packet(input logic [15:0] len, input logic [1:0] ver,
                             input logic mark, input logic [31:0] sip,
                             input logic [31:0] ts, input logic [31:0] ssrc,
                             input logic [15:0] seq, input logic [31:0] arr);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= IN_TDATA_W'({arr, seq, ssrc, ts, sip, mark, ver, len});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and let every predicted record come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly locked-stream traffic, plus noise, foreign SSRCs and rejects
  task automatic random_packet();
    int          roll, step;
    bit          incoming;
    logic [15:0] len, seq;
    logic [1:0]  ver;
    logic        mark;
    logic [31:0] sip, ts, ssrc, arr;
    roll = $urandom_range(0, 99);
    incoming = ($urandom_range(0, 3) != 0);
    len = 16'($urandom_range(16'hFFFF, len_floor_now));
    ver = 2'($urandom_range(1, 2));
    mark = ($urandom_range(0, 7) == 0);
    sip = $urandom;
    if (sip == host_ip_now) sip = sip ^ 32'd1;
    if (!incoming) sip = host_ip_now;
    seq = seq_ctr;
    seq_ctr = seq_ctr + 16'd1;
    ts = $urandom;
    arr = $urandom;
    ssrc = incoming ? rx_ssrc_now : tx_ssrc_now;
    if (roll < 60) begin
      // incoming stream with plausible timing, now and then a wild jump
      if (incoming) begin
        step = $urandom_range(1, 4);
        if (roll < 4) begin
          rx_ts = $urandom;
          rx_arrival = $urandom;
        end else begin
          rx_ts = rx_ts + 32'(160 * step);
          rx_arrival = rx_arrival + 32'(10000 * step) + $urandom_range(0, 6000) - 32'd3000;
        end
        ts = rx_ts;
        arr = rx_arrival;
      end
    end else if (roll < 80) begin
      len = 16'($urandom);
      ver = 2'($urandom);
      mark = 1'($urandom);
      seq = 16'($urandom);
      ssrc = $urandom;
      if ($urandom_range(0, 3) == 0) sip = host_ip_now;
      else sip = $urandom;
    end else if (roll < 90) begin
      // other streams, often with a start marker
      ssrc = $urandom;
      mark = 1'($urandom);
      if (mark) ts = '0;
    end else begin
      if (len_floor_now != 16'd0 && $urandom_range(0, 1))
        len = 16'($urandom_range(len_floor_now - 1, 0));
      else ver = $urandom_range(0, 1) ? RTP_VER1 - 2'd1 : 2'd3;
    end
    push_packet(len, ver, mark, sip, ts, ssrc, seq, arr);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: length and version rejects, unlocked traffic
    push_packet(16'd0, RTP_VER2, 1'b0, 32'd5, 32'd1, 32'd9, 16'd0, 32'd0);
    push_packet(16'd33, RTP_VER2, 1'b1, 32'd5, 32'd0, 32'd9, 16'd1, 32'd0);
    push_packet(16'd34, 2'd0, 1'b1, 32'd5, 32'd0, 32'd9, 16'd2, 32'd0);
    push_packet(16'd34, 2'd3, 1'b1, 32'd0, 32'd0, 32'd9, 16'd3, 32'd0);
    push_packet(16'hFFFF, RTP_VER1, 1'b1, 32'd0, 32'd7, 32'd9, 16'd4, 32'd0);
    push_packet(16'd34, RTP_VER2, 1'b0, 32'd1, 32'd0, 32'd9, 16'd5, 32'd0);
    wait_drained();

    write_reg(REG_LOCAL_IP, HOST_A);
    write_reg(REG_MIN_LENGTH, 32'd12);
    write_reg(REG_MASTER_MODE, 32'd1);
    host_ip_now = HOST_A;
    len_floor_now = 16'd12;

    // Lock both directions; the second lock pulses the report
    push_packet(16'd11, RTP_VER2, 1'b1, HOST_A, 32'd0, TX_SSRC_A, 16'd10, 32'd0);
    push_packet(16'd12, RTP_VER2, 1'b1, HOST_A, 32'd0, TX_SSRC_A, 16'd11, 32'd50);
    push_packet(16'd80, RTP_VER2, 1'b0, HOST_A, 32'd160, TX_SSRC_A, 16'd12, 32'd60);
    push_packet(16'd80, RTP_VER2, 1'b1, HOST_A, 32'd0, 32'hFFFF_FFFF, 16'd13, 32'd70);
    push_packet(16'd80, RTP_VER2, 1'b0, PEER_A, 32'd0, RX_SSRC_A, 16'd14, 32'd80);
    push_packet(16'd80, RTP_VER2, 1'b1, PEER_A, 32'd0, RX_SSRC_A, 16'd15, 32'd1000);
    push_packet(16'd80, RTP_VER1, 1'b1, PEER_A, 32'd0, 32'd0, 16'd16, 32'd1100);
    // Jitter: exact pacing, late arrival, extreme positive and negative deltas, wrap
    push_packet(16'd80, RTP_VER2, 1'b0, PEER_A, 32'd160, RX_SSRC_A, 16'd17, 32'd11000);
    push_packet(16'd80, RTP_VER2, 1'b0, PEER_A, 32'd320, RX_SSRC_A, 16'd18, 32'd23500);
    push_packet(16'd80, RTP_VER2, 1'b0, PEER_A, 32'h8000_013F, RX_SSRC_A, 16'd19,
                32'd23505);
    push_packet(16'd80, RTP_VER2, 1'b0, PEER_A, 32'h0000_0140, RX_SSRC_A, 16'd20,
                32'd23505 + 32'h8000_0000);
    push_packet(16'hFFFF, RTP_VER1, 1'b0, PEER_A, 32'hFFFF_FFFF, RX_SSRC_A, 16'hFFFF,
                32'hFFFF_FFFF);
    push_packet(16'd80, RTP_VER2, 1'b1, PEER_A, 32'd0, RX_SSRC_A, 16'd21, 32'd0);
    push_packet(16'hFFFF, RTP_VER1, 1'b0, HOST_A, 32'hFFFF_FFFF, TX_SSRC_A, 16'd22,
                32'hFFFF_FFFF);
    push_packet(16'd80, 2'd3, 1'b0, PEER_A, 32'd480, RX_SSRC_A, 16'd23, 32'd30000);
    tx_ssrc_now = TX_SSRC_A;
    rx_ssrc_now = RX_SSRC_A;

    // Random traffic under four setups and four idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        1: begin
          write_reg(REG_LOCAL_IP, 32'hFFFF_FFFF);
          write_reg(REG_MIN_LENGTH, 32'd0);
          write_reg(REG_MASTER_MODE, 32'hFFFF_FFFE);
          write_reg(REG_PRESET_OUT_SSRC, 32'd0);
          write_reg(REG_PRESET_IN_SSRC, 32'hFFFF_FFFF);
          write_reg(REG_PRESET_LOCK, 32'd1);
          write_reg(CFG_IDX_SPARE_A, $urandom);
          write_reg(CFG_IDX_SPARE_B, $urandom);
          host_ip_now = 32'hFFFF_FFFF;
          len_floor_now = 16'd0;
          tx_ssrc_now = 32'd0;
          rx_ssrc_now = 32'hFFFF_FFFF;
          idle_pct = 47;
          stall_pct = 0;
        end
        2: begin
          // new presets without a lock request leave the locks alone
          preset_tx_val = $urandom;
          preset_rx_val = $urandom;
          write_reg(REG_LOCAL_IP, 32'd0);
          write_reg(REG_MIN_LENGTH, 32'hFFFF_FFFF);
          write_reg(REG_MASTER_MODE, 32'd1);
          write_reg(REG_PRESET_OUT_SSRC, preset_tx_val);
          write_reg(REG_PRESET_IN_SSRC, preset_rx_val);
          write_reg(REG_PRESET_LOCK, 32'd0);
          host_ip_now = 32'd0;
          len_floor_now = 16'hFFFF;
          idle_pct = 0;
          stall_pct = 47;
        end
        3: begin
          host_ip_now = $urandom;
          write_reg(REG_LOCAL_IP, host_ip_now);
          write_reg(REG_MIN_LENGTH, 32'd100);
          write_reg(REG_MASTER_MODE, 32'd0);
          write_reg(REG_PRESET_LOCK, 32'hFFFF_FFFF);
          len_floor_now = 16'd100;
          tx_ssrc_now = preset_tx_val;
          rx_ssrc_now = preset_rx_val;
          idle_pct = 26;
          stall_pct = 26;
        end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (160) random_packet();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rtp_stream_lock_jitter_monitor_test: clean");
    end else begin
      $display("rtp_stream_lock_jitter_monitor_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/rtpjm_pkg.sv
src/rtpjm_jitter_pipe.sv
src/rtp_stream_lock_jitter_monitor.sv
verif/rtp_stream_lock_jitter_monitor_checker.sv
verif/rtp_stream_lock_jitter_monitor_test.sv
